>>> rtl/bba_pkg.sv
package bba_pkg;

    localparam int BLK_W   = 27;
    localparam int IN_W    = 88;
    localparam int OUT_W   = 40;
    localparam int Q_DEPTH = 2;

    typedef enum logic [2:0] {
        REQ_FIND  = 3'd0,
        REQ_NEXT  = 3'd1,
        REQ_RSV   = 3'd2,
        REQ_FREE  = 3'd3,
        REQ_RFREE = 3'd4,
        REQ_RUSED = 3'd5,
        REQ_STAT  = 3'd6,
        REQ_NONE  = 3'd7
    } req_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOFREE = 2'd1,
        ST_RANGE  = 2'd2
    } status_t;

    typedef struct packed {
        req_t             op;
        logic [BLK_W-1:0] start_blk;
        logic [BLK_W-1:0] end_blk;
    } cmd_t;

endpackage

>>> rtl/bba_front.sv
module bba_front import bba_pkg::*; #(
    parameter int BLOCK_SIZE_LOG2 = 12
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [IN_W-1:0] s_tdata,
    output logic            out_valid,
    input  logic            out_ready,
    output cmd_t            out_cmd
);

    logic        v_reg;
    cmd_t        cmd_reg;
    cmd_t        cmd_next;
    req_t        req;
    logic [31:0] rs;
    logic [31:0] re;
    logic [32:0] re_up;

    assign s_tready  = en && (!v_reg || out_ready);
    assign out_valid = v_reg;
    assign out_cmd   = cmd_reg;

    assign req   = req_t'(s_tdata[2:0]);
    assign rs    = s_tdata[49:18];
    assign re    = s_tdata[81:50];
    assign re_up = {1'b0, re} + 33'((64'd1 << BLOCK_SIZE_LOG2) - 64'd1);

    always_comb begin
        cmd_next.op      = req;
        cmd_next.end_blk = BLK_W'(re_up >> BLOCK_SIZE_LOG2);
        case (req)
            REQ_RSV, REQ_FREE, REQ_STAT: begin
                cmd_next.start_blk = BLK_W'(s_tdata[17:3]);
            end
            REQ_NEXT: begin
                cmd_next.start_blk = '0;
            end
            default: begin
                cmd_next.start_blk = BLK_W'(rs >> BLOCK_SIZE_LOG2);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            v_reg <= 1'b1;
        end else if (out_ready) begin
            v_reg <= 1'b0;
        end
        if (s_tvalid && s_tready) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

>>> rtl/bba_fifo.sv
module bba_fifo import bba_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    cmd_t       q_reg [Q_DEPTH];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (cnt_reg != 2'(Q_DEPTH));
    assign out_valid = (cnt_reg != 2'd0);
    assign out_cmd   = q_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wp_reg <= ~wp_reg;
            end
            if (pop) begin
                rp_reg <= ~rp_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
        if (push) begin
            q_reg[wp_reg] <= in_cmd;
        end
    end

endmodule

>>> rtl/bba_engine.sv
module bba_engine import bba_pkg::*; #(
    parameter int MAX_BLOCKS = 32768,
    parameter int CNT_W      = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [CNT_W-1:0] eff_total,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  cmd_t             cmd,
    output logic             init_done,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    localparam int MAP_WORDS = (MAX_BLOCKS + 31) / 32;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int WW        = CNT_W - 5;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SC_RD, S_SC_EV, S_BIT_RD, S_BIT_EV,
        S_RG_RD, S_RG_EV, S_RG_CNT, S_DONE
    } state_t;

    state_t           state_reg;
    req_t             op_reg;
    logic [WW-1:0]    word_reg;
    logic [CNT_W-1:0] lo_reg;
    logic [CNT_W-1:0] hi_reg;
    logic [CNT_W-1:0] fc_reg;
    logic [31:0]      diff_reg;
    status_t          st_reg;
    logic [CNT_W-1:0] fnd_reg;
    logic             used_reg;
    logic             m_valid_reg;
    logic [OUT_W-1:0] m_data_reg;

    logic [31:0]      mem [MAP_WORDS];
    logic [31:0]      rdata;
    logic             we;
    logic [31:0]      wdata;

    logic [CNT_W-1:0] nm1;
    logic [4:0]       lo_b;
    logic [4:0]       hi_b;
    logic [31:0]      mask;
    logic [31:0]      cand;
    logic [4:0]       cidx;
    logic [4:0]       bsel;
    logic             old_b;
    logic             new_b;
    logic [31:0]      rg_new;
    logic [5:0]       pc;
    logic [CNT_W-1:0] end_clip;
    logic [CNT_W-1:0] ub;

    assign cmd_ready = (state_reg == S_IDLE);
    assign init_done = (state_reg != S_INIT);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign nm1  = eff_total - CNT_W'(1);
    assign lo_b = (word_reg == lo_reg[CNT_W-1:5]) ? lo_reg[4:0] : 5'd0;
    assign bsel = lo_reg[4:0];
    assign old_b = rdata[bsel];

    always_comb begin
        if (state_reg == S_SC_EV) begin
            hi_b = (word_reg == nm1[CNT_W-1:5]) ? nm1[4:0] : 5'd31;
        end else begin
            hi_b = (word_reg == hi_reg[CNT_W-1:5]) ? hi_reg[4:0] : 5'd31;
        end
        for (int i = 0; i < 32; i++) begin
            mask[i] = (5'(i) >= lo_b) && (5'(i) <= hi_b);
        end
    end

    assign cand   = ~rdata & mask;
    assign rg_new = (op_reg == REQ_RUSED) ? (rdata | mask) : (rdata & ~mask);

    always_comb begin
        cidx = 5'd0;
        for (int i = 31; i >= 0; i--) begin
            if (cand[i]) begin
                cidx = 5'(i);
            end
        end
    end

    always_comb begin
        case (op_reg)
            REQ_RSV:  new_b = 1'b1;
            REQ_FREE: new_b = 1'b0;
            default:  new_b = old_b;
        endcase
    end

    always_comb begin
        pc = 6'd0;
        for (int i = 0; i < 32; i++) begin
            pc = pc + 6'(diff_reg[i]);
        end
    end

    assign end_clip = (32'(cmd.end_blk) > 32'(eff_total)) ? eff_total
                                                          : CNT_W'(cmd.end_blk);
    assign ub = (eff_total > fc_reg) ? (eff_total - fc_reg) : '0;

    always_comb begin
        we    = 1'b0;
        wdata = rdata;
        case (state_reg)
            S_INIT: begin
                we    = 1'b1;
                wdata = '1;
            end
            S_SC_EV: begin
                we    = (cand != 32'd0) && (op_reg == REQ_NEXT);
                wdata = rdata | (32'd1 << cidx);
            end
            S_BIT_EV: begin
                we    = (new_b != old_b);
                wdata = new_b ? (rdata | (32'd1 << bsel)) : (rdata & ~(32'd1 << bsel));
            end
            S_RG_EV: begin
                we    = 1'b1;
                wdata = rg_new;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[word_reg[AW-1:0]] <= wdata;
        end
        rdata <= mem[word_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            word_reg    <= '0;
            fc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_tready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_INIT: begin
                    if (word_reg == WW'(MAP_WORDS - 1)) begin
                        state_reg <= S_IDLE;
                    end else begin
                        word_reg <= word_reg + WW'(1);
                    end
                end
                S_IDLE: begin
                    if (cmd_valid) begin
                        op_reg   <= cmd.op;
                        st_reg   <= ST_OK;
                        fnd_reg  <= '0;
                        used_reg <= 1'b0;
                        lo_reg   <= CNT_W'(cmd.start_blk);
                        word_reg <= WW'(cmd.start_blk >> 5);
                        hi_reg   <= end_clip - CNT_W'(1);
                        case (cmd.op)
                            REQ_FIND, REQ_NEXT: begin
                                if (32'(cmd.start_blk) >= 32'(eff_total)) begin
                                    st_reg    <= ST_NOFREE;
                                    state_reg <= S_DONE;
                                end else begin
                                    state_reg <= S_SC_RD;
                                end
                            end
                            REQ_RSV, REQ_FREE, REQ_STAT: begin
                                if (32'(cmd.start_blk) >= 32'(eff_total)) begin
                                    st_reg    <= ST_RANGE;
                                    state_reg <= S_DONE;
                                end else begin
                                    state_reg <= S_BIT_RD;
                                end
                            end
                            REQ_RFREE, REQ_RUSED: begin
                                if (32'(cmd.start_blk) >= 32'(end_clip)) begin
                                    state_reg <= S_DONE;
                                end else begin
                                    state_reg <= S_RG_RD;
                                end
                            end
                            default: begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SC_RD: begin
                    state_reg <= S_SC_EV;
                end
                S_SC_EV: begin
                    if (cand != 32'd0) begin
                        fnd_reg <= {word_reg, cidx};
                        if (op_reg == REQ_NEXT) begin
                            used_reg <= 1'b1;
                            fc_reg   <= fc_reg - CNT_W'(1);
                        end
                        state_reg <= S_DONE;
                    end else if (word_reg == nm1[CNT_W-1:5]) begin
                        st_reg    <= ST_NOFREE;
                        state_reg <= S_DONE;
                    end else begin
                        word_reg  <= word_reg + WW'(1);
                        state_reg <= S_SC_RD;
                    end
                end
                S_BIT_RD: begin
                    state_reg <= S_BIT_EV;
                end
                S_BIT_EV: begin
                    if (new_b != old_b) begin
                        fc_reg <= new_b ? (fc_reg - CNT_W'(1)) : (fc_reg + CNT_W'(1));
                    end
                    fnd_reg   <= lo_reg;
                    used_reg  <= new_b;
                    state_reg <= S_DONE;
                end
                S_RG_RD: begin
                    state_reg <= S_RG_EV;
                end
                S_RG_EV: begin
                    diff_reg  <= rdata ^ rg_new;
                    state_reg <= S_RG_CNT;
                end
                S_RG_CNT: begin
                    fc_reg <= (op_reg == REQ_RUSED) ? (fc_reg - CNT_W'(pc))
                                                    : (fc_reg + CNT_W'(pc));
                    if (word_reg == hi_reg[CNT_W-1:5]) begin
                        state_reg <= S_DONE;
                    end else begin
                        word_reg  <= word_reg + WW'(1);
                        state_reg <= S_RG_RD;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {6'd0, 16'(ub), used_reg, 15'(fnd_reg), st_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/block_bitmap_allocator.sv
// Bitmap allocator with one used bit per memory block, held in a memory of 32-bit
// words. After reset the block sweeps the map to all-used, one word per cycle,
// and takes no request meanwhile. Requests enter a decode stage and a two-deep
// queue, so new beats are taken while the engine works or a result waits. The
// engine takes a request from the queue, works on the map and then loads the
// result register. Single block reserve, free and status read one word and write
// it back if the bit changes; searches read and test each 32-block word in turn
// from the start word; region marks read, write and count each word covered.
// Rejected, empty and unused requests go straight to the result register.
// The word-serial memory port sets the rate.
module block_bitmap_allocator import bba_pkg::*; #(
    parameter int MAX_BLOCKS      = 32768,
    parameter int BLOCK_SIZE_LOG2 = 12
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wen,
    input  logic [15:0]      cfg_wdata,  // total_blocks
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,    // req_type, block_index, region_start, region_end
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata     // status, found_index, block_used, used_blocks
);

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    logic [15:0]      total_reg;
    logic [CNT_W-1:0] eff_total;
    logic             init_done;
    logic             f_valid;
    logic             f_ready;
    cmd_t             f_cmd;
    logic             q_valid;
    logic             q_ready;
    cmd_t             q_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= 16'd32768;
        end else if (cfg_wen) begin
            total_reg <= cfg_wdata;
        end
    end

    assign eff_total = (32'(total_reg) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS)
                                                     : CNT_W'(total_reg);

    bba_front #(
        .BLOCK_SIZE_LOG2(BLOCK_SIZE_LOG2)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (init_done),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_cmd   (f_cmd)
    );

    bba_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    bba_engine #(
        .MAX_BLOCKS(MAX_BLOCKS),
        .CNT_W     (CNT_W)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .eff_total (eff_total),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .init_done (init_done),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != ST_OK) |-> (m_tdata[17:2] == 16'd0))
        else $error("failed request carries index or used bit");

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'(m_tdata[33:18]) <= 32'(eff_total)))
        else $error("used count above total");

    a_init_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !init_done |-> !s_tready && !m_tvalid)
        else $error("beat taken during map clear");

endmodule
